@@ rtl/ftlx_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ftlx_pkg
// shared widths and constants of the four-tap lagged-xor generator
// ----------------------------------------------------------------------------
package ftlx_pkg;

  // generator word width
  localparam int WORD_W = 31;

  // park-miller multiplier and its width
  localparam int MULT_W = 15;
  localparam logic [MULT_W-1:0] PM_MULT = 15'd16807;

  // mersenne prime 2^31-1
  localparam logic [WORD_W-1:0] PM_PRIME = 31'h7FFF_FFFF;

  // reset seed
  localparam logic [WORD_W-1:0] SEED_RESET = 31'd817;

  // lags behind the current position
  localparam int LAG_A = 471;
  localparam int LAG_B = 1586;
  localparam int LAG_C = 6988;
  localparam int LAG_D = 9689;

  // tap select codes
  typedef enum logic [1:0] {
    TAP_A = 2'd0,
    TAP_B = 2'd1,
    TAP_C = 2'd2,
    TAP_D = 2'd3
  } tap_sel_t;

  // sequencer states
  typedef enum logic [6:0] {
    ST_FILL_MUL = 7'b000_0001,
    ST_FILL_WR  = 7'b000_0010,
    ST_IDLE     = 7'b000_0100,
    ST_TAP      = 7'b000_1000,
    ST_XOR_WR   = 7'b001_0000,
    ST_DIV      = 7'b010_0000,
    ST_OUT      = 7'b100_0000
  } state_t;

endpackage : ftlx_pkg
`default_nettype wire

@@ rtl/ftlx_mod_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ftlx_mod_unit
// restoring modulo, one dividend bit per cycle
// ----------------------------------------------------------------------------
module ftlx_mod_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [ftlx_pkg::WORD_W-1:0]  dividend,
  input  wire logic [ftlx_pkg::WORD_W-1:0]  divisor,
  output logic                              done,
  output logic [ftlx_pkg::WORD_W-1:0]       remainder
);

  localparam int CNT_W = $clog2(ftlx_pkg::WORD_W);

  logic                           busy;
  logic [CNT_W-1:0]               cnt;
  logic [ftlx_pkg::WORD_W-1:0]    quo;
  logic [ftlx_pkg::WORD_W-1:0]    dsr;
  logic [ftlx_pkg::WORD_W:0]      trial;
  logic [ftlx_pkg::WORD_W:0]      diff;

  // shift next dividend bit into the partial remainder
  assign trial = {remainder, quo[ftlx_pkg::WORD_W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // last step of an operation raises done for one cycle
      done <= busy && !start && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ftlx_pkg::WORD_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo       <= dividend;
      dsr       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      quo <= {quo[ftlx_pkg::WORD_W-2:0], 1'b0};
      if (!diff[ftlx_pkg::WORD_W]) begin
        remainder <= diff[ftlx_pkg::WORD_W-1:0];
      end else begin
        remainder <= trial[ftlx_pkg::WORD_W-1:0];
      end
    end
  end

  // a new operation never lands on one in flight
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("mod unit started while busy");

  // done marks the end of an operation
  a_done_end: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("mod unit done while still busy");

  // the remainder stays below the divisor once finished
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    done && (dsr != '0) |-> remainder < dsr)
    else $error("mod unit remainder out of range");

endmodule : ftlx_mod_unit
`default_nettype wire

@@ rtl/four_tap_lagged_xor_rng.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// four_tap_lagged_xor_rng
// four-tap lagged-xor random number generator with bounded draw
// ----------------------------------------------------------------------------
// A table of TABLE_DEPTH 31-bit words sits in one single-port memory. After
// reset, and after every seed write, the table is refilled with successive
// minimal-standard park-miller values (x*16807 mod 2^31-1) starting from the
// seed; the refill runs a multiply state and then a fold-and-write state for
// every table entry, one entry after the other, and no request
// word is taken during it. Each request advances the position, reads the four
// lagged taps (471, 1586, 6988, 9689 behind it) one per cycle through the
// memory port, writes their xor back at the position, and then reduces that
// raw word modulo the requested modulus in a restoring unit that takes one
// bit per cycle. The time from acceptance to the result being loaded is
// set by the four tap reads on the single memory port and the 31 steps of
// the modulo unit; a zero modulus skips the modulo. The result register
// lets the next request start while a result still waits on out_stall.
// The seed is written through cfg_we/cfg_wdata and leaves the position
// unchanged.
// ----------------------------------------------------------------------------
module four_tap_lagged_xor_rng #(
  parameter int TABLE_DEPTH = 16384
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // seed register
  input  wire logic                         cfg_we,
  input  wire logic [ftlx_pkg::WORD_W-1:0]  cfg_wdata,
  // request words
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [ftlx_pkg::WORD_W-1:0]  modulus,
  // result words
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [ftlx_pkg::WORD_W-1:0]       bounded_value,
  output logic [ftlx_pkg::WORD_W-1:0]       raw_word,
  output logic                              modulus_error
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int WORD_W = ftlx_pkg::WORD_W;
  localparam int PROD_W = ftlx_pkg::WORD_W + ftlx_pkg::MULT_W;

  ftlx_pkg::state_t    state;
  ftlx_pkg::tap_sel_t  tap_cnt;

  logic [WORD_W-1:0]   seed;
  logic [WORD_W-1:0]   pm_x;
  logic [PROD_W-1:0]   prod;
  logic [WORD_W-1:0]   pm_fold;
  logic [WORD_W:0]     fold_sum;
  logic [WORD_W:0]     fold_sub;
  logic [IDX_W-1:0]    fill_idx;
  logic [IDX_W-1:0]    position;
  logic [WORD_W-1:0]   mod_reg;
  logic [WORD_W-1:0]   acc;
  logic                rd_pend;
  logic [WORD_W-1:0]   new_word;
  logic [WORD_W-1:0]   res_bounded;
  logic [WORD_W-1:0]   res_raw;
  logic                res_err;

  // table memory
  logic [WORD_W-1:0]   mem [TABLE_DEPTH];
  logic [IDX_W-1:0]    mem_addr;
  logic                mem_we;
  logic [WORD_W-1:0]   mem_wdata;
  logic [WORD_W-1:0]   rd_data;

  // modulo unit
  logic                div_start;
  logic                div_done;
  logic [WORD_W-1:0]   div_rem;

  logic                in_acc;
  logic                out_free;
  logic                out_load;
  logic [IDX_W-1:0]    lag;

  assign in_stall = (state != ftlx_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  // result register can take a word this cycle
  assign out_free = !out_valid || !out_stall;
  // finished word moves into the result register
  assign out_load = (state == ftlx_pkg::ST_OUT) && out_free && !cfg_we;

  // mod 2^31-1 fold: hi part adds back, one conditional subtract
  assign fold_sum = {1'b0, prod[WORD_W-1:0]} + (WORD_W+1)'(prod[PROD_W-1:WORD_W]);
  assign fold_sub = fold_sum - {1'b0, ftlx_pkg::PM_PRIME};
  assign pm_fold  = fold_sub[WORD_W] ? fold_sum[WORD_W-1:0] : fold_sub[WORD_W-1:0];

  // last tap arrives in the xor-write cycle
  assign new_word = acc ^ rd_data;

  always_comb begin
    case (tap_cnt)
      ftlx_pkg::TAP_A: lag = IDX_W'(ftlx_pkg::LAG_A);
      ftlx_pkg::TAP_B: lag = IDX_W'(ftlx_pkg::LAG_B);
      ftlx_pkg::TAP_C: lag = IDX_W'(ftlx_pkg::LAG_C);
      ftlx_pkg::TAP_D: lag = IDX_W'(ftlx_pkg::LAG_D);
      default:         lag = IDX_W'(ftlx_pkg::LAG_A);
    endcase
  end

  // single memory port: fill writes, tap reads, word write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = new_word;
    mem_addr  = position;
    case (state)
      ftlx_pkg::ST_FILL_WR: begin
        mem_we    = 1'b1;
        mem_wdata = pm_fold;
        mem_addr  = fill_idx;
      end
      ftlx_pkg::ST_TAP: begin
        mem_addr = position - lag;
      end
      ftlx_pkg::ST_XOR_WR: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_addr = position;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[mem_addr];
  end

  assign div_start = (state == ftlx_pkg::ST_XOR_WR) && (mod_reg != '0);

  ftlx_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (new_word),
    .divisor   (mod_reg),
    .done      (div_done),
    .remainder (div_rem)
  );

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ftlx_pkg::ST_FILL_MUL;
      seed      <= ftlx_pkg::SEED_RESET;
      pm_x      <= ftlx_pkg::SEED_RESET;
      fill_idx  <= '0;
      position  <= '0;
      tap_cnt   <= ftlx_pkg::TAP_A;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= (state == ftlx_pkg::ST_TAP);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        // new seed restarts the fill
        seed     <= cfg_wdata;
        pm_x     <= cfg_wdata;
        fill_idx <= '0;
        state    <= ftlx_pkg::ST_FILL_MUL;
      end else begin
        case (state)
          ftlx_pkg::ST_FILL_MUL: begin
            state <= ftlx_pkg::ST_FILL_WR;
          end
          ftlx_pkg::ST_FILL_WR: begin
            pm_x     <= pm_fold;
            fill_idx <= fill_idx + 1'b1;
            if (&fill_idx) begin
              state <= ftlx_pkg::ST_IDLE;
            end else begin
              state <= ftlx_pkg::ST_FILL_MUL;
            end
          end
          ftlx_pkg::ST_IDLE: begin
            if (in_acc) begin
              position <= position + 1'b1;
              tap_cnt  <= ftlx_pkg::TAP_A;
              state    <= ftlx_pkg::ST_TAP;
            end
          end
          ftlx_pkg::ST_TAP: begin
            tap_cnt <= ftlx_pkg::tap_sel_t'(tap_cnt + 2'd1);
            if (tap_cnt == ftlx_pkg::TAP_D) begin
              state <= ftlx_pkg::ST_XOR_WR;
            end
          end
          ftlx_pkg::ST_XOR_WR: begin
            if (mod_reg == '0) begin
              state <= ftlx_pkg::ST_OUT;
            end else begin
              state <= ftlx_pkg::ST_DIV;
            end
          end
          ftlx_pkg::ST_DIV: begin
            if (div_done) begin
              state <= ftlx_pkg::ST_OUT;
            end
          end
          ftlx_pkg::ST_OUT: begin
            if (out_free) begin
              state <= ftlx_pkg::ST_IDLE;
            end
          end
          default: begin
            state <= ftlx_pkg::ST_IDLE;
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ftlx_pkg::ST_FILL_MUL) begin
      prod <= pm_x * ftlx_pkg::PM_MULT;
    end
    if (in_acc) begin
      mod_reg <= modulus;
      acc     <= '0;
    end else if ((state == ftlx_pkg::ST_TAP) && rd_pend) begin
      acc <= acc ^ rd_data;
    end
    if (state == ftlx_pkg::ST_XOR_WR) begin
      res_raw     <= new_word;
      res_err     <= (mod_reg == '0);
      res_bounded <= '0;
    end
    if ((state == ftlx_pkg::ST_DIV) && div_done) begin
      res_bounded <= div_rem;
    end
    if (out_load) begin
      bounded_value <= res_bounded;
      raw_word      <= res_raw;
      modulus_error <= res_err;
    end
  end

  // an accepted request goes straight to the tap reads
  a_acc_tap: assert property (@(posedge clk) disable iff (rst)
    in_acc && !cfg_we |=> state == ftlx_pkg::ST_TAP)
    else $error("accepted request did not start tap reads");

  // a zero-modulus result carries a zero bounded value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && modulus_error |-> bounded_value == '0)
    else $error("error result with nonzero bounded value");

  // a finished draw is below its modulus
  a_res_range: assert property (@(posedge clk) disable iff (rst)
    (state == ftlx_pkg::ST_OUT) && !res_err |-> res_bounded < mod_reg)
    else $error("bounded value not below modulus");

  // the seed register only changes on a write
  a_seed_hold: assert property (@(posedge clk) disable iff (rst)
    !cfg_we |=> $stable(seed))
    else $error("seed changed without a write");

endmodule : four_tap_lagged_xor_rng
`default_nettype wire
